FILE: sv/rau_pkg.sv
// rau_pkg: shared types and codes of the rational arithmetic unit
// depends on nothing; used by the top level and the channel interfaces
package rau_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_COMB,
        S_RED,
        S_GSH,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_CHK,
        S_OUT
    } t_state;

    typedef logic [2:0] t_mode;
    typedef logic [1:0] t_status;

    localparam t_mode MODE_NORM   = 3'd0;
    localparam t_mode MODE_ADD    = 3'd1;
    localparam t_mode MODE_SUB    = 3'd2;
    localparam t_mode MODE_MUL    = 3'd3;
    localparam t_mode MODE_DIV    = 3'd4;
    localparam t_mode MODE_LT     = 3'd5;
    localparam t_mode MODE_EQ     = 3'd6;
    localparam t_mode MODE_UNUSED = 3'd7;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_ZERO_DEN = 2'd1;
    localparam t_status ST_OVF      = 2'd2;

endpackage

FILE: sv/rau_req_if.sv
// rau_req_if: request channel carrying an operation code and two fractions
// depends on rau_pkg for the mode type
interface rau_req_if;
    logic                valid;
    logic                ready;
    rau_pkg::t_mode      mode;
    logic signed [31:0]  a_num;
    logic signed [31:0]  a_den;
    logic signed [31:0]  b_num;
    logic        [30:0]  b_den;

    modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

FILE: sv/rau_rsp_if.sv
// rau_rsp_if: response channel carrying the reduced fraction, flag and status
// depends on rau_pkg for the status type
interface rau_rsp_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  res_num;
    logic        [30:0]  res_den;
    logic                cmp_true;
    rau_pkg::t_status    status;

    modport source (output valid, res_num, res_den, cmp_true, status, input ready);
    modport sink   (input valid, res_num, res_den, cmp_true, status, output ready);
endinterface

FILE: sv/rational_arithmetic_unit.sv
// sequence after accept: errors and the unused mode go straight to the output stage,
// compares run two multiplies and the combine; normalize starts at the reduction, multiply
// and divide add two multiplies, add and subtract three plus a possible combine retry;
// then the data-dependent binary gcd loop and 4*WORD_BITS restoring division steps; a zero result skips both
// one request at a time: ready returns the cycle after the response is loaded
// reset: synchronous active-low i_rst_n returns the sequencer to idle, no output
module rational_arithmetic_unit #(
    parameter int WORD_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_req_if.sink   i_req,
    rau_rsp_if.source o_rsp
);
    import rau_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int W2 = 2 * WORD_BITS;
    localparam int KW = $clog2(W2 + 1);
    localparam int CW = $clog2(W2);
    localparam logic [CW-1:0] CNT_LAST = CW'(W2 - 1);
    localparam logic [W2-1:0] HALF     = W2'(1) << (W - 1);

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic [W-1:0]  r_xm, n_xm, r_xd, n_xd, r_ym, n_ym, r_yd, n_yd;
    logic [W2-1:0] r_p1, n_p1, r_p2, n_p2, r_num, n_num, r_den, n_den;
    logic [W2-1:0] r_u, n_u, r_v, n_v;
    logic          r_sx, n_sx, r_sy, n_sy, r_neg, n_neg;
    logic [KW-1:0] r_k, n_k;
    logic [CW-1:0] r_cnt, n_cnt;
    // staged result
    logic [31:0]   r_s_num, n_s_num;
    logic [30:0]   r_s_den, n_s_den;
    logic          r_s_cmp, n_s_cmp;
    t_status       r_s_st, n_s_st;
    // output register
    logic          r_ovalid, n_ovalid;
    logic [31:0]   r_o_num, n_o_num;
    logic [30:0]   r_o_den, n_o_den;
    logic          r_o_cmp, n_o_cmp;
    t_status       r_o_st, n_o_st;

    // operand decode from the request
    logic [W-1:0] in_an, in_ad, in_bn, in_am, in_adm, in_bm, in_bd;
    logic         accept, in_zero_den, in_div_zero;

    assign in_an  = i_req.a_num[W-1:0];
    assign in_ad  = i_req.a_den[W-1:0];
    assign in_bn  = i_req.b_num[W-1:0];
    assign in_am  = in_an[W-1] ? (~in_an + 1'b1) : in_an;
    assign in_adm = in_ad[W-1] ? (~in_ad + 1'b1) : in_ad;
    assign in_bm  = in_bn[W-1] ? (~in_bn + 1'b1) : in_bn;
    assign in_bd  = {1'b0, i_req.b_den[W-2:0]};
    assign in_zero_den = (in_ad == '0) || ((i_req.mode != MODE_NORM) && (in_bd == '0));
    assign in_div_zero = (i_req.mode == MODE_DIV) && (in_bn == '0);

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);

    // shared multiplier
    logic [W-1:0]  mul_a, mul_b;
    logic [W2-1:0] mul_p;

    always_comb begin
        mul_a = r_xd;
        mul_b = r_yd;
        unique case (r_state)
            S_MUL1: begin
                mul_a = r_xm;
                mul_b = (r_mode == MODE_MUL) ? r_ym : r_yd;
            end
            S_MUL2: begin
                mul_a = r_xd;
                mul_b = (r_mode == MODE_MUL) ? r_yd : r_ym;
            end
            default: begin
                mul_a = r_xd;
                mul_b = r_yd;
            end
        endcase
    end
    assign mul_p = W2'(mul_a) * W2'(mul_b);

    // shared subtractor: add/sub and compares, gcd, division
    logic [W2-1:0] sub_x, sub_y, remsh, sub_d;
    logic [W2:0]   sub_full;
    logic          sub_borrow;

    assign remsh = (r_state == S_DIVD) ? {r_v[W2-2:0], r_den[W2-1]}
                                       : {r_v[W2-2:0], r_num[W2-1]};
    always_comb begin
        unique case (r_state)
            S_COMB:         begin sub_x = r_p1;  sub_y = r_p2; end
            S_GCD:          begin sub_x = r_v;   sub_y = r_u;  end
            S_DIVN, S_DIVD: begin sub_x = remsh; sub_y = r_u;  end
            default:        begin sub_x = r_p1;  sub_y = r_p2; end
        endcase
    end
    assign sub_full   = {1'b0, sub_x} - {1'b0, sub_y};
    assign sub_d      = sub_full[W2-1:0];
    assign sub_borrow = sub_full[W2];

    // compare flags on the cross products
    logic vx, vy, lt_flag, eq_flag;
    assign vx      = r_sx && (r_p1 != '0);
    assign vy      = r_sy && (r_p2 != '0);
    assign lt_flag = (vx && !vy) || (!vx && !vy && sub_borrow)
                   || (vx && vy && !sub_borrow && (sub_d != '0));
    assign eq_flag = (vx == vy) && (sub_d == '0);

    // signed result and range check
    logic [W2-1:0]    sval;
    logic [W2+31:0]   sext;
    logic [W2+30:0]   dext;
    logic             fits;
    assign sval = r_neg ? (~r_num + 1'b1) : r_num;
    assign sext = {{32{sval[W2-1]}}, sval};
    assign dext = {31'b0, r_den};
    assign fits = (r_neg ? (r_num <= HALF) : (r_num <= HALF - 1'b1))
                  && (r_den <= HALF - 1'b1);

    logic out_free;
    assign out_free = !r_ovalid || o_rsp.ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.mode == MODE_UNUSED || in_zero_den || in_div_zero)
                        n_state = S_OUT;
                    else if (i_req.mode == MODE_NORM)
                        n_state = S_RED;
                    else
                        n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: begin
                if (r_mode == MODE_ADD || r_mode == MODE_SUB) n_state = S_MUL3;
                else n_state = S_COMB;
            end
            S_MUL3: n_state = S_COMB;
            S_COMB: begin
                if (r_mode == MODE_LT || r_mode == MODE_EQ)
                    n_state = S_OUT;
                else if ((r_mode == MODE_ADD || r_mode == MODE_SUB)
                         && r_sx != r_sy && sub_borrow)
                    n_state = S_COMB;
                else
                    n_state = S_RED;
            end
            S_RED:  n_state = (r_num == '0) ? S_OUT : S_GSH;
            S_GSH:  n_state = (!r_u[0] && !r_v[0]) ? S_GSH : S_GCD;
            S_GCD:  n_state = (r_v == '0) ? S_DIVN : S_GCD;
            S_DIVN: n_state = (r_cnt == CNT_LAST) ? S_DIVD : S_DIVN;
            S_DIVD: n_state = (r_cnt == CNT_LAST) ? S_CHK : S_DIVD;
            S_CHK:  n_state = S_OUT;
            S_OUT:  n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_mode = r_mode; n_xm = r_xm; n_xd = r_xd; n_ym = r_ym; n_yd = r_yd;
        n_p1 = r_p1; n_p2 = r_p2; n_num = r_num; n_den = r_den;
        n_u = r_u; n_v = r_v; n_sx = r_sx; n_sy = r_sy; n_neg = r_neg;
        n_k = r_k; n_cnt = r_cnt;
        n_s_num = r_s_num; n_s_den = r_s_den; n_s_cmp = r_s_cmp; n_s_st = r_s_st;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode = i_req.mode;
                    n_xm = in_am; n_xd = in_adm; n_ym = in_bm; n_yd = in_bd;
                    n_sx = in_an[W-1] ^ in_ad[W-1];
                    n_sy = in_bn[W-1] ^ (i_req.mode == MODE_SUB);
                    n_num = W2'(in_am);
                    n_den = W2'(in_adm);
                    n_neg = in_an[W-1] ^ in_ad[W-1];
                    n_s_num = '0; n_s_cmp = 1'b0;
                    if (i_req.mode == MODE_UNUSED) begin
                        n_s_den = 31'd1; n_s_st = ST_OK;
                    end else begin
                        n_s_den = '0; n_s_st = ST_ZERO_DEN;
                    end
                end
            end
            S_MUL1: n_p1 = mul_p;
            S_MUL2: n_p2 = mul_p;
            S_MUL3: n_den = mul_p;
            S_COMB: begin
                n_s_num = '0; n_s_den = '0; n_s_st = ST_OK;
                n_s_cmp = (r_mode == MODE_LT) ? lt_flag : eq_flag;
                if (r_mode == MODE_MUL || r_mode == MODE_DIV) begin
                    n_num = r_p1; n_den = r_p2; n_neg = r_sx ^ r_sy;
                end else if (r_sx == r_sy) begin
                    n_num = r_p1 + r_p2; n_neg = r_sx;
                end else if (sub_borrow) begin
                    // larger magnitude to the left, retry
                    n_p1 = r_p2; n_p2 = r_p1; n_sx = r_sy; n_sy = r_sx;
                end else begin
                    n_num = sub_d; n_neg = r_sx;
                end
            end
            S_RED: begin
                n_u = r_num; n_v = r_den; n_k = '0;
                n_s_num = '0; n_s_den = 31'd1; n_s_cmp = 1'b0; n_s_st = ST_OK;
            end
            S_GSH: begin
                if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1; n_v = r_v >> 1; n_k = r_k + 1'b1;
                end
            end
            S_GCD: begin
                if (r_v == '0) begin
                    n_u = r_u << r_k; n_cnt = '0;
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (sub_borrow) begin
                    n_u = r_v; n_v = r_u;
                end else begin
                    n_v = sub_d;
                end
            end
            S_DIVN, S_DIVD: begin
                // one restoring division step, quotient shifts into the operand
                n_v = sub_borrow ? remsh : sub_d;
                if (r_state == S_DIVN) n_num = {r_num[W2-2:0], !sub_borrow};
                else                   n_den = {r_den[W2-2:0], !sub_borrow};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_cnt = '0; n_v = '0;
                end
            end
            S_CHK: begin
                n_s_cmp = 1'b0;
                if (fits) begin
                    n_s_num = sext[31:0]; n_s_den = dext[30:0]; n_s_st = ST_OK;
                end else begin
                    n_s_num = '0; n_s_den = '0; n_s_st = ST_OVF;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_comb begin
        n_ovalid = r_ovalid;
        n_o_num = r_o_num; n_o_den = r_o_den; n_o_cmp = r_o_cmp; n_o_st = r_o_st;
        if (r_ovalid && o_rsp.ready) n_ovalid = 1'b0;
        if (r_state == S_OUT && out_free) begin
            n_ovalid = 1'b1;
            n_o_num = r_s_num; n_o_den = r_s_den; n_o_cmp = r_s_cmp; n_o_st = r_s_st;
        end
    end

    assign o_rsp.valid    = r_ovalid;
    assign o_rsp.res_num  = r_o_num;
    assign o_rsp.res_den  = r_o_den;
    assign o_rsp.cmp_true = r_o_cmp;
    assign o_rsp.status   = r_o_st;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode; r_xm <= n_xm; r_xd <= n_xd; r_ym <= n_ym; r_yd <= n_yd;
        r_p1 <= n_p1; r_p2 <= n_p2; r_num <= n_num; r_den <= n_den;
        r_u <= n_u; r_v <= n_v; r_sx <= n_sx; r_sy <= n_sy; r_neg <= n_neg;
        r_k <= n_k; r_cnt <= n_cnt;
        r_s_num <= n_s_num; r_s_den <= n_s_den; r_s_cmp <= n_s_cmp; r_s_st <= n_s_st;
        r_o_num <= n_o_num; r_o_den <= n_o_den; r_o_cmp <= n_o_cmp; r_o_st <= n_o_st;
    end

endmodule

FILE: tb/sv/rau_checker.sv
// rau_checker: watches both channels of the rational arithmetic unit, predicts
// each response from the accepted request and compares field by field; uses rau_pkg
module rau_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rau_req_if     req,
    rau_rsp_if     rsp,
    output int     o_errors,
    output int     o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    typedef struct packed {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic               cmp;
        t_status            st;
    } t_answer;

    t_answer answer_q[$];
    int      errors = 0;

    assign o_errors  = errors;
    assign o_pending = answer_q.size();

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // reduce a signed-magnitude fraction, zero becomes 0/1
    function automatic void reduce_frac(inout logic neg, inout logic [63:0] mag,
                                        inout logic [63:0] den);
        logic [63:0] g;
        if (mag == 0) begin
            neg = 1'b0;
            den = 64'd1;
        end else begin
            g   = gcd64(mag, den);
            mag = mag / g;
            den = den / g;
        end
    endfunction

    function automatic t_answer pack_frac(logic neg, logic [63:0] mag, logic [63:0] den);
        t_answer r;
        logic [63:0] lim;
        lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
        r   = '0;
        if (mag > lim || den > 64'h7fff_ffff)
            r.st = ST_OVF;
        else begin
            r.num = neg ? -mag[31:0] : mag[31:0];
            r.den = den[30:0];
            r.st  = ST_OK;
        end
        return r;
    endfunction

    function automatic t_answer compute_rational(t_mode mode, logic signed [31:0] an,
            logic signed [31:0] ad, logic signed [31:0] bn, logic [30:0] bd);
        t_answer r;
        logic aneg, bneg, rneg;
        logic [63:0] amag, aden, bmag, bden, rmag, rden, x, y;
        logic signed [63:0] sa, sb;
        r = '0;
        if (mode == MODE_UNUSED) begin
            r.den = 31'd1;
            return r;
        end
        if (ad == 0 || (mode != MODE_NORM && bd == 0)) begin
            r.st = ST_ZERO_DEN;
            return r;
        end
        aneg = (an < 0) != (ad < 0);
        amag = an < 0 ? -64'(an) : 64'(an);
        aden = ad < 0 ? -64'(ad) : 64'(ad);
        reduce_frac(aneg, amag, aden);
        if (mode == MODE_NORM) return pack_frac(aneg, amag, aden);
        bneg = bn < 0;
        bmag = bn < 0 ? -64'(bn) : 64'(bn);
        bden = 64'(bd);
        reduce_frac(bneg, bmag, bden);
        case (mode)
            MODE_ADD, MODE_SUB: begin
                x = amag * bden;
                y = bmag * aden;
                if (mode == MODE_SUB) bneg = !bneg;
                if (aneg == bneg) begin
                    rneg = aneg; rmag = x + y;
                end else if (x >= y) begin
                    rneg = aneg; rmag = x - y;
                end else begin
                    rneg = bneg; rmag = y - x;
                end
                rden = aden * bden;
            end
            MODE_MUL: begin
                rneg = aneg != bneg;
                rmag = amag * bmag;
                rden = aden * bden;
            end
            MODE_DIV: begin
                if (bmag == 0) begin
                    r.st = ST_ZERO_DEN;
                    return r;
                end
                rneg = aneg != bneg;
                rmag = amag * bden;
                rden = aden * bmag;
            end
            MODE_LT: begin
                sa = aneg ? -$signed(amag) : $signed(amag);
                sb = bneg ? -$signed(bmag) : $signed(bmag);
                r.cmp = (sa * $signed(bden)) < (sb * $signed(aden));
                return r;
            end
            default: begin
                r.cmp = aneg == bneg && amag == bmag && aden == bden;
                return r;
            end
        endcase
        reduce_frac(rneg, rmag, rden);
        return pack_frac(rneg, rmag, rden);
    endfunction

    // predict on accepted requests, compare on accepted responses
    always @(posedge i_clk) begin
        t_answer want, got;
        if (i_rst_n) begin
            if (req.valid && req.ready)
                answer_q.insert(answer_q.size(),
                                compute_rational(req.mode, req.a_num, req.a_den,
                                                 req.b_num, req.b_den));
            if (rsp.valid && rsp.ready) begin
                got = {rsp.res_num, rsp.res_den, rsp.cmp_true, rsp.status};
                if (answer_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected response %p", got);
                end else begin
                    want = answer_q.pop_front();
                    if (want != got) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
        end
    end
endmodule

FILE: tb/sv/testbench.sv
// testbench: drives requests into the rational arithmetic unit under varying
// idle and stall phases; depends on rau_pkg, the channel interfaces, rau_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending;
    int   send_idle = 0;
    int   stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_on = 1'b0;

    rau_req_if req ();
    rau_rsp_if rsp ();

    rational_arithmetic_unit dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req), .o_rsp(rsp));
    rau_checker chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .req(req), .rsp(rsp),
                     .o_errors(errors), .o_pending(pending));

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // response side: random stalls, held off entirely during the long hold
    always @(posedge i_clk) begin
        if (!i_rst_n)
            rsp.ready <= 1'b0;
        else if (hold_on)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(99) >= stall_pct);
    end

    // long hold-off on responses, counted in cycles here
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (2000) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0: return $urandom_range(20) - 10;
            1: return $signed($urandom_range(2000)) - 1000;
            2: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            3: return $signed($urandom_range(65535)) - 32768;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_den();
        case ($urandom_range(4))
            0: return 31'($urandom_range(12));
            1: return 31'($urandom_range(1000));
            2: return 31'h7fff_ffff;
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic send_request(t_mode m, logic signed [31:0] an, logic signed [31:0] ad,
                                logic signed [31:0] bn, logic [30:0] bd);
        while ($urandom_range(99) < send_idle) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.mode <= m; req.a_num <= an; req.a_den <= ad; req.b_num <= bn; req.b_den <= bd;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
    endtask

    task automatic send_random(int count);
        t_mode m;
        for (int i = 0; i < count; i++) begin
            m = t_mode'($urandom_range(7));
            send_request(m, rand_word(), rand_word(), rand_word(), rand_den());
        end
        req.valid <= 1'b0;
    endtask

    initial begin
        req.valid = 1'b0; req.mode = MODE_NORM;
        req.a_num = 0; req.a_den = 1; req.b_num = 0; req.b_den = 1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every mode, field extremes, zero and error cases
        send_request(MODE_NORM, 6, -4, 0, 0);
        send_request(MODE_NORM, 32'sh8000_0000, -1, 0, 1);
        send_request(MODE_NORM, 32'sh8000_0000, 1, 0, 1);
        send_request(MODE_NORM, 5, 0, 1, 1);
        send_request(MODE_NORM, 0, -7, 3, 2);
        send_request(MODE_ADD, 1, 2, 1, 3);
        send_request(MODE_ADD, 1, 3, 1, 0);
        send_request(MODE_ADD, 32'sh7fff_ffff, 1, 32'sh7fff_ffff, 1);
        send_request(MODE_SUB, 1, 2, 1, 2);
        send_request(MODE_SUB, 32'sh8000_0000, 1, 1, 1);
        send_request(MODE_SUB, -3, -4, 32'sh8000_0000, 31'h7fff_ffff);
        send_request(MODE_MUL, 32'sh7fff_ffff, 32'sh7fff_fffe, 2, 31'h7fff_ffff);
        send_request(MODE_MUL, 32'sh8000_0000, 32'sh8000_0000, -1, 1);
        send_request(MODE_DIV, 3, 4, 0, 5);
        send_request(MODE_DIV, 3, 4, -9, 8);
        send_request(MODE_DIV, 1, 32'sh7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff);
        send_request(MODE_LT, -1, 2, 1, 3);
        send_request(MODE_LT, 1, 2, 1, 2);
        send_request(MODE_LT, 32'sh7fff_ffff, -1, 32'sh8000_0000, 1);
        send_request(MODE_EQ, 2, 4, 1, 2);
        send_request(MODE_EQ, 2, -4, 1, 2);
        send_request(MODE_UNUSED, 32'sh7fff_ffff, 0, -1, 0);
        send_request(MODE_UNUSED, 0, 1, 0, 31'h7fff_ffff);
        req.valid <= 1'b0;

        // random phases with varying idle and stall pressure
        send_idle = 0;  stall_pct = 0;  send_random(400);
        send_idle = 83; stall_pct = 0;  send_random(350);
        send_idle = 0;  stall_pct = 83; send_random(350);
        send_idle = 33; stall_pct = 33; send_random(350);
        // long hold-off on responses while requests keep coming
        send_idle = 0;  stall_pct = 0;  hold_go = 1'b1;
        send_random(350);

        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial begin
        #40ms;
        $display("testbench: errors");
        $finish;
    end
endmodule
